// ----- rtl/merkle_layer_sha256_pairer_defines.svh -----
// Assertion macros shared by the RTL of the Merkle layer pairer.
`ifndef MERKLE_LAYER_SHA256_PAIRER_DEFINES_SVH
`define MERKLE_LAYER_SHA256_PAIRER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MLSP_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MLSP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/mlsp_pkg.sv -----
// Types, constants and SHA-256 helper functions for the Merkle layer pairer.
package mlsp_pkg;

  typedef enum logic [2:0] {
    S_IN,
    S_PASS,
    S_LOAD,
    S_RND1,
    S_FIN1,
    S_RND2,
    S_FIN2,
    S_OUT
  } state_t;

  typedef logic [7:0][31:0] hash_vec_t;
  typedef logic [15:0][31:0] sched_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam hash_vec_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] PAD_FIRST = 32'h80000000;
  localparam logic [31:0] PAD_LEN   = 32'd512;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/mlsp_in_if.sv -----
// Input digest-word channel.
interface mlsp_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] in_word;

  modport source (output valid, output in_word, input ready);
  modport sink (input valid, input in_word, output ready);
endinterface

// ----- rtl/mlsp_out_if.sv -----
// Result digest-word channel.
interface mlsp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic        digest_end;
  logic        layer_end;

  modport source (output valid, output out_word, output digest_end, output layer_end,
                  input ready);
  modport sink (input valid, input out_word, input digest_end, input layer_end,
                output ready);
endinterface

// ----- rtl/mlsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mlsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/merkle_layer_sha256_pairer.sv -----
// Top level of the Merkle layer pairer: input buffer, SHA-256 engine and output register.
//
// Digest words are stored in an 8-entry pair buffer RAM as they arrive, one per cycle
// while the block is in its input state. After the eighth word of a pair the block stops
// taking input, loads the message schedule from the buffer, runs two 64-round
// compressions at one round per cycle with the feed-forward adds after each, and emits
// four result words as the output accepts them. An unpaired last digest is read back
// from the buffer and passed through. Words beyond the layer count (saturated at
// MAX_LAYER_NODES) are taken and dropped.
`include "merkle_layer_sha256_pairer_defines.svh"

module merkle_layer_sha256_pairer #(
  parameter longint unsigned MAX_LAYER_NODES = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  mlsp_in_if.sink     in_ch,
  mlsp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [33:0] MAX_W = 34'(MAX_LAYER_NODES);

  mlsp_pkg::state_t    state_r, state_nxt;
  logic [20:0]         count_r, count_nxt;
  logic [20:0]         seen_r, seen_nxt;
  logic [2:0]          wpos_r, wpos_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                last_r, last_nxt;
  mlsp_pkg::hash_vec_t h_r, h_nxt;
  mlsp_pkg::hash_vec_t v_r, v_nxt;
  mlsp_pkg::sched_t    w_r, w_nxt;
  logic                ov_r, ov_nxt;
  logic [63:0]         ow_r, ow_nxt;
  logic                de_r, de_nxt;
  logic                le_r, le_nxt;

  logic        ram_we;
  logic [2:0]  ram_raddr;
  logic [63:0] ram_rdata;
  logic [20:0] eff_count;
  logic        slot;
  logic        cfg_wr;
  logic [31:0] t1, t2, w_new;
  mlsp_pkg::hash_vec_t h_sum;

  mlsp_ram #(.WIDTH(64), .DEPTH(8)) u_pair_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos_r),
    .wdata (in_ch.in_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pready    = 1'b1;
  assign prdata    = {11'd0, count_r};
  assign cfg_wr    = psel && penable && pwrite && (paddr == 3'd0);
  assign eff_count = ({13'd0, count_r} > MAX_W) ? MAX_W[20:0] : count_r;
  assign slot      = !ov_r || out_ch.ready;
  assign ram_raddr = (state_r == mlsp_pkg::S_PASS) ? {1'b0, cnt_r[1:0]} : cnt_r[2:0];

  assign in_ch.ready       = (state_r == mlsp_pkg::S_IN);
  assign ram_we            = in_ch.valid && in_ch.ready && (seen_r < eff_count);
  assign out_ch.valid      = ov_r;
  assign out_ch.out_word   = ow_r;
  assign out_ch.digest_end = de_r;
  assign out_ch.layer_end  = le_r;

  assign t1 = v_r[7] + mlsp_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + mlsp_pkg::K_TAB[cnt_r] + w_r[0];
  assign t2 = mlsp_pkg::bsig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = w_r[0] + mlsp_pkg::ssig0(w_r[1]) + w_r[9] + mlsp_pkg::ssig1(w_r[14]);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_sum[i] = h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlsp_pkg::S_IN;
      count_r <= 21'd1;
      seen_r  <= '0;
      wpos_r  <= '0;
      cnt_r   <= '0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      wpos_r  <= wpos_nxt;
      cnt_r   <= cnt_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
    h_r  <= h_nxt;
    v_r  <= v_nxt;
    w_r  <= w_nxt;
    ow_r <= ow_nxt;
    de_r <= de_nxt;
    le_r <= le_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    wpos_nxt  = wpos_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    h_nxt     = h_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    ov_nxt    = ov_r && !out_ch.ready;
    ow_nxt    = ow_r;
    de_nxt    = de_r;
    le_nxt    = le_r;

    unique case (state_r)
      mlsp_pkg::S_IN: begin
        if (ram_we) begin
          wpos_nxt = wpos_r + 3'd1;
          cnt_nxt  = '0;
          if (wpos_r == 3'd3 && ({1'b0, seen_r} + 22'd1) == {1'b0, eff_count}) begin
            seen_nxt  = seen_r + 21'd1;
            wpos_nxt  = '0;
            state_nxt = mlsp_pkg::S_PASS;
          end else if (wpos_r == 3'd7) begin
            seen_nxt  = seen_r + 21'd2;
            last_nxt  = ({1'b0, seen_r} + 22'd2) == {1'b0, eff_count};
            state_nxt = mlsp_pkg::S_LOAD;
          end
        end
        if (cfg_wr) begin
          count_nxt = pwdata[20:0];
          seen_nxt  = '0;
          wpos_nxt  = '0;
        end
      end
      mlsp_pkg::S_PASS: begin
        // cnt_r[2] flags that read data for entry cnt_r[1:0] is valid
        if (!cnt_r[2]) begin
          cnt_nxt = {cnt_r[5:3], 1'b1, cnt_r[1:0]};
        end else if (slot) begin
          ov_nxt  = 1'b1;
          ow_nxt  = ram_rdata;
          de_nxt  = (cnt_r[1:0] == 2'd3);
          le_nxt  = (cnt_r[1:0] == 2'd3);
          cnt_nxt = {4'd0, cnt_r[1:0] + 2'd1};
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt   = '0;
            state_nxt = mlsp_pkg::S_IN;
          end
        end
      end
      mlsp_pkg::S_LOAD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r != 6'd0) begin
          for (int i = 0; i < 14; i++) begin
            w_nxt[i] = w_r[i+2];
          end
          w_nxt[14] = ram_rdata[63:32];
          w_nxt[15] = ram_rdata[31:0];
        end
        if (cnt_r == 6'd8) begin
          cnt_nxt   = '0;
          h_nxt     = mlsp_pkg::SHA_IV;
          v_nxt     = mlsp_pkg::SHA_IV;
          state_nxt = mlsp_pkg::S_RND1;
        end
      end
      mlsp_pkg::S_RND1, mlsp_pkg::S_RND2: begin
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        v_nxt[7]  = v_r[6];
        v_nxt[6]  = v_r[5];
        v_nxt[5]  = v_r[4];
        v_nxt[4]  = v_r[3] + t1;
        v_nxt[3]  = v_r[2];
        v_nxt[2]  = v_r[1];
        v_nxt[1]  = v_r[0];
        v_nxt[0]  = t1 + t2;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = (state_r == mlsp_pkg::S_RND1) ? mlsp_pkg::S_FIN1 : mlsp_pkg::S_FIN2;
        end
      end
      mlsp_pkg::S_FIN1: begin
        h_nxt     = h_sum;
        v_nxt     = h_sum;
        w_nxt     = '0;
        w_nxt[0]  = mlsp_pkg::PAD_FIRST;
        w_nxt[15] = mlsp_pkg::PAD_LEN;
        cnt_nxt   = '0;
        state_nxt = mlsp_pkg::S_RND2;
      end
      mlsp_pkg::S_FIN2: begin
        h_nxt     = h_sum;
        cnt_nxt   = '0;
        state_nxt = mlsp_pkg::S_OUT;
      end
      mlsp_pkg::S_OUT: begin
        if (slot) begin
          ov_nxt  = 1'b1;
          ow_nxt  = {h_r[{cnt_r[1:0], 1'b0}], h_r[{cnt_r[1:0], 1'b1}]};
          de_nxt  = (cnt_r[1:0] == 2'd3);
          le_nxt  = (cnt_r[1:0] == 2'd3) && last_r;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt   = '0;
            state_nxt = mlsp_pkg::S_IN;
          end
        end
      end
      default: begin
        state_nxt = mlsp_pkg::S_IN;
      end
    endcase
  end

  `MLSP_ASSERT_IMPLY(a_layer_end_on_digest_end, clk, rst_n,
    out_ch.valid && out_ch.layer_end, out_ch.digest_end)
  `MLSP_ASSERT_NEXT(a_round_loop_exit, clk, rst_n,
    state_r == mlsp_pkg::S_RND1 && cnt_r == 6'd63, state_r == mlsp_pkg::S_FIN1)
  `MLSP_ASSERT_IMPLY(a_seen_within_count, clk, rst_n,
    state_r == mlsp_pkg::S_IN && !cfg_wr, seen_r <= eff_count)

endmodule

// ----- tb/mlsp_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the Merkle layer pairer: SHA-256 pair hashing and result checks.
package mlsp_tb_pkg;

  localparam int unsigned LAYER_CAP = 1048576;

  typedef struct packed {
    logic [63:0] word;
    logic        digest_end;
    logic        layer_end;
  } parent_word_t;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  class layer_scoreboard;
    logic [20:0]  count_reg;
    logic [63:0]  words [8];
    int unsigned  pos;
    int unsigned  taken;
    parent_word_t pending [$];
    int unsigned  errors;
    int unsigned  results_seen;
    int unsigned  parents, passes;

    function new();
      count_reg = 21'd1;
      pos = 0;
      taken = 0;
      errors = 0;
      results_seen = 0;
      parents = 0;
      passes = 0;
    endfunction

    function void set_count(logic [20:0] v);
      count_reg = v;
      pos = 0;
      taken = 0;
    endfunction

    function int unsigned eff_count();
      return (count_reg > LAYER_CAP) ? LAYER_CAP : count_reg;
    endfunction

    function void compress(ref logic [31:0] h [8], input logic [31:0] blk [16]);
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + w[i-7]
             + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
             + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mlsp_pkg::K_TAB[i] + w[i];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
    endfunction

    function void note_input(logic [63:0] w);
      logic [31:0] h [8];
      logic [31:0] blk [16];
      parent_word_t r;
      if (taken >= eff_count()) return;
      words[pos] = w;
      pos = (pos + 1) % 8;
      if (pos == 4) begin
        if (taken + 1 != eff_count()) return;
        taken++;
        pos = 0;
        passes++;
        for (int i = 0; i < 4; i++) begin
          r.word = words[i];
          r.digest_end = (i == 3);
          r.layer_end = (i == 3);
          pending.push_back(r);
        end
        return;
      end
      if (pos != 0) return;
      taken += 2;
      parents++;
      for (int i = 0; i < 8; i++) h[i] = mlsp_pkg::SHA_IV[i];
      for (int i = 0; i < 8; i++) begin
        blk[2*i] = words[i][63:32];
        blk[2*i+1] = words[i][31:0];
      end
      compress(h, blk);
      foreach (blk[i]) blk[i] = '0;
      blk[0] = mlsp_pkg::PAD_FIRST;
      blk[15] = mlsp_pkg::PAD_LEN;
      compress(h, blk);
      for (int i = 0; i < 4; i++) begin
        r.word = {h[2*i], h[2*i+1]};
        r.digest_end = (i == 3);
        r.layer_end = (i == 3) && (taken == eff_count());
        pending.push_back(r);
      end
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check_result(parent_word_t got);
      parent_word_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", got.word));
        return;
      end
      exp = pending.pop_front();
      if (got.word !== exp.word)
        report($sformatf("word %h, expected %h", got.word, exp.word));
      if (got.digest_end !== exp.digest_end)
        report($sformatf("digest_end %b, expected %b", got.digest_end, exp.digest_end));
      if (got.layer_end !== exp.layer_end)
        report($sformatf("layer_end %b, expected %b", got.layer_end, exp.layer_end));
    endfunction
  endclass
endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the Merkle layer pairer.
module tb;

  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  longint cycles = 0;
  bit stall_long = 1'b0;
  bit stim_done = 1'b0;
  int unsigned fed = 0;

  mlsp_in_if in_ch ();
  mlsp_out_if out_ch ();

  mlsp_tb_pkg::layer_scoreboard sb = new();

  merkle_layer_sha256_pairer dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_word = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.out_word, out_ch.digest_end, out_ch.layer_end});
  end

  always @(posedge clk) begin
    if (stall_long) out_ch.ready <= 1'b0;
    else if (cycles % 64 < 40) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == 3'd0) sb.set_count(data[20:0]);
  endtask

  task automatic send_word(logic [63:0] w);
    in_ch.valid <= 1'b1;
    in_ch.in_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(w);
    fed++;
  endtask

  task automatic maybe_gap();
    int g;
    if ($urandom_range(0, 3) == 0) begin
      g = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic run_layer(int unsigned n, int unsigned nwords);
    cfg_write(3'd0, n);
    for (int i = 0; i < nwords; i++) begin
      send_word(rand64());
      maybe_gap();
    end
    drain();
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset count of one: single digest passes through
    send_word(64'h0);
    send_word('1);
    send_word(64'h8000_0000_0000_0001);
    send_word(64'h0123_4567_89ab_cdef);
    send_word(64'hdead_beef_0000_0000); // beyond count, dropped
    drain();
    cfg_write(3'd4, 32'd5); // unknown register
    cfg_write(3'd0, 32'd2);
    for (int i = 0; i < 8; i++) send_word(i[0] ? '1 : 64'h0);
    drain();
    cfg_write(3'd0, 32'd0); // zero count ignores all
    for (int i = 0; i < 4; i++) send_word(rand64());
    drain();
    // large count, saturated at capacity; take one pair
    run_layer(32'h001f_ffff, 8);
    run_layer(mlsp_tb_pkg::LAYER_CAP, 8);
    run_layer(3, 12);
    // long receiver hold-off with the sender running
    cfg_write(3'd0, 32'd6);
    stall_long = 1'b1;
    fork
      begin repeat (600) @(posedge clk); stall_long = 1'b0; end
      for (int i = 0; i < 24; i++) send_word(rand64());
    join
    drain();
    while (fed < 470) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 9);
      run_layer(n, 4 * n + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0));
    end
    drain();
    $display("covered %0d input words, %0d parent hashes, %0d pass-through digests",
             fed, sb.parents, sb.passes);
    $display("layer counts from zero to above capacity, with output stalls");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mlsp_pkg.sv
rtl/mlsp_in_if.sv
rtl/mlsp_out_if.sv
rtl/mlsp_ram.sv
rtl/merkle_layer_sha256_pairer.sv
tb/mlsp_tb_pkg.sv
tb/tb.sv
